// ===== rtl/urs_pkg.sv =====
// Shared types and constants for the ultrasonic ranging and steering block.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package urs_pkg;

  // Event codes on the command field.
  typedef enum logic [1:0] {
    CMD_TRIGGER = 2'd0,
    CMD_ECHO    = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  // Configuration register indexes.
  localparam int unsigned    CFG_IDX_W           = 3;
  localparam logic [2:0]     REG_RETRY_LIMIT     = 3'd0;
  localparam logic [2:0]     REG_TIMEOUT_STEP    = 3'd1;
  localparam logic [2:0]     REG_TIMEOUT_CAP     = 3'd2;
  localparam logic [2:0]     REG_MIN_ECHO_COUNT  = 3'd3;
  localparam logic [2:0]     REG_FOLLOW_DISTANCE = 3'd4;

  // Configuration reset values.
  localparam logic [3:0]     RETRY_LIMIT_RST     = 4'd10;
  localparam logic [9:0]     TIMEOUT_STEP_RST    = 10'd200;
  localparam logic [15:0]    TIMEOUT_CAP_RST     = 16'd3000;
  localparam logic [7:0]     MIN_ECHO_COUNT_RST  = 8'd10;
  localparam logic [9:0]     FOLLOW_DISTANCE_RST = 10'd150;

  localparam logic [15:0]    DIST_RST            = 16'hFFFF;

  // Echo conversion: floor(count*17/100) = (count*ECHO_MULT) >> ECHO_SHIFT
  // for every 16-bit count; the rounding error stays below 1/100.
  localparam int unsigned    ECHO_SHIFT          = 24;
  localparam logic [21:0]    ECHO_MULT           = 22'd2852127;

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic [9:0]  timeout_step;
    logic [15:0] timeout_cap;
    logic [7:0]  min_echo_count;
    logic [9:0]  follow_distance;
  } cfg_t;

  // One word handed from the sensor front end to the steering back end.
  typedef struct packed {
    logic [15:0] front_dist;
    logic [15:0] side_dist;
    logic        fire;
    logic        run_steer;
  } evt_t;

  localparam int unsigned    QUEUE_DEPTH         = 2;
  localparam int unsigned    QPTR_W              = $clog2(QUEUE_DEPTH);

  // Steering arithmetic is done in a signed word wide enough for 7*65535.
  typedef logic signed [23:0] steer_t;

  localparam steer_t BACK_ENTER   = 24'sd80;
  localparam steer_t BACK_EXIT    = 24'sd200;
  localparam steer_t BACK_BASE    = 24'sd1200;
  localparam steer_t TURN_ENTER   = 24'sd230;
  localparam steer_t TURN_SIDE    = 24'sd250;
  localparam steer_t TURN_EXIT    = 24'sd400;
  localparam steer_t TURN_GAIN    = 24'sd300;
  localparam steer_t FWD_OFFSET   = 24'sd120;
  localparam steer_t SIDE_ENTER   = 24'sd70;
  localparam steer_t SIDE_TURN    = 24'sd300;
  localparam steer_t SIDE_MARGIN  = 24'sd20;
  localparam steer_t FOLLOW_BASE  = 24'sd500;
  localparam steer_t FOLLOW_REF   = 24'sd80;
  localparam steer_t CRUISE_FWD   = 24'sd1000;
  localparam steer_t TERM_LIMIT   = 24'sd1000;

endpackage

`default_nettype wire

// ===== rtl/ultrasonic_ranging_steering.sv =====
// Ultrasonic ranging and steering: sensor front end, event queue, steering back end.
// An accepted word is written into a queue slot and popped into the output register.
// Throughput: one word per cycle unless stalled; the front end updates the distances in the
// accepting cycle and the back end runs the steering rule in the cycle it pops the queue.
// Reset: distances go to 65535, wait state, modes and held drives clear, registers
// take their default values; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_ranging_steering (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic        channel_i,
  input  wire logic [15:0] echo_count_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [11:0]      left_drive_o,
  output logic [11:0]      right_drive_o,
  output logic [15:0]      front_distance_o,
  output logic [15:0]      side_distance_o,
  output logic             fire_pulse_o,
  output logic             drive_updated_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [urs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  urs_pkg::cfg_t cfg_q;
  urs_pkg::evt_t push_word;
  urs_pkg::evt_t pop_word;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_limit     <= urs_pkg::RETRY_LIMIT_RST;
      cfg_q.timeout_step    <= urs_pkg::TIMEOUT_STEP_RST;
      cfg_q.timeout_cap     <= urs_pkg::TIMEOUT_CAP_RST;
      cfg_q.min_echo_count  <= urs_pkg::MIN_ECHO_COUNT_RST;
      cfg_q.follow_distance <= urs_pkg::FOLLOW_DISTANCE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        urs_pkg::REG_RETRY_LIMIT:     cfg_q.retry_limit     <= cfg_data_i[3:0];
        urs_pkg::REG_TIMEOUT_STEP:    cfg_q.timeout_step    <= cfg_data_i[9:0];
        urs_pkg::REG_TIMEOUT_CAP:     cfg_q.timeout_cap     <= cfg_data_i;
        urs_pkg::REG_MIN_ECHO_COUNT:  cfg_q.min_echo_count  <= cfg_data_i[7:0];
        urs_pkg::REG_FOLLOW_DISTANCE: cfg_q.follow_distance <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  urs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .command_i    (command_i),
    .channel_i    (channel_i),
    .echo_count_i (echo_count_i),
    .cfg_i        (cfg_q),
    .evt_o        (push_word)
  );

  urs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (push_word),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_word)
  );

  urs_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .evt_valid_i       (q_valid),
    .evt_i             (pop_word),
    .pop_o             (q_pop),
    .follow_distance_i (cfg_q.follow_distance),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .left_drive_o      (left_drive_o),
    .right_drive_o     (right_drive_o),
    .front_distance_o  (front_distance_o),
    .side_distance_o   (side_distance_o),
    .fire_pulse_o      (fire_pulse_o),
    .drive_updated_o   (drive_updated_o)
  );

endmodule

`default_nettype wire

// ===== rtl/urs_front.sv =====
// Sensor front end: takes events, keeps per-channel wait state and both
// distance estimates, and emits one event word per item. Uses urs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urs_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [1:0]    command_i,
  input  wire logic          channel_i,
  input  wire logic [15:0]   echo_count_i,
  input  wire urs_pkg::cfg_t cfg_i,
  output urs_pkg::evt_t      evt_o
);

  logic [15:0] front_dist_q, front_dist_d;
  logic [15:0] side_dist_q, side_dist_d;
  logic        waiting_q [2];
  logic        waiting_d [2];
  logic [3:0]  missed_q [2];
  logic [3:0]  missed_d [2];

  logic [15:0] cur_dist;
  logic [15:0] new_dist;
  logic [37:0] echo_prod;
  logic [16:0] step_sum;
  logic [3:0]  missed_inc;
  logic        fire;
  logic        run_steer;
  urs_pkg::cmd_e cmd;

  assign cmd        = urs_pkg::cmd_e'(command_i);
  assign cur_dist   = channel_i ? side_dist_q : front_dist_q;
  assign echo_prod  = 38'(echo_count_i) * 38'(urs_pkg::ECHO_MULT);
  assign step_sum   = {1'b0, cur_dist} + {7'b0, cfg_i.timeout_step};
  assign missed_inc = missed_q[channel_i] + 4'd1;

  always_comb begin
    waiting_d    = waiting_q;
    missed_d     = missed_q;
    new_dist     = cur_dist;
    fire         = 1'b0;
    run_steer    = 1'b0;
    unique case (cmd)
      urs_pkg::CMD_TRIGGER: begin
        if (waiting_q[channel_i]) begin
          // A trigger while still waiting counts as a missed echo.
          if (missed_inc >= cfg_i.retry_limit) begin
            missed_d[channel_i]  = 4'd0;
            waiting_d[channel_i] = 1'b0;
          end else begin
            missed_d[channel_i] = missed_inc;
          end
        end else begin
          waiting_d[channel_i] = 1'b1;
          fire                 = 1'b1;
        end
      end
      urs_pkg::CMD_ECHO: begin
        if (waiting_q[channel_i] && (echo_count_i >= {8'b0, cfg_i.min_echo_count})) begin
          new_dist             = 16'(echo_prod[37:urs_pkg::ECHO_SHIFT]);
          waiting_d[channel_i] = 1'b0;
          run_steer            = 1'b1;
        end
      end
      urs_pkg::CMD_TIMEOUT: begin
        waiting_d[channel_i] = 1'b0;
        if (cur_dist < cfg_i.timeout_cap) begin
          new_dist = step_sum[16] ? 16'hFFFF : step_sum[15:0];
        end
        run_steer = 1'b1;
      end
      urs_pkg::CMD_UNUSED: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    front_dist_d = front_dist_q;
    side_dist_d  = side_dist_q;
    if (channel_i) begin
      side_dist_d = new_dist;
    end else begin
      front_dist_d = new_dist;
    end
  end

  assign evt_o.front_dist = front_dist_d;
  assign evt_o.side_dist  = side_dist_d;
  assign evt_o.fire       = fire;
  assign evt_o.run_steer  = run_steer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_dist_q <= urs_pkg::DIST_RST;
      side_dist_q  <= urs_pkg::DIST_RST;
      waiting_q[0] <= 1'b0;
      waiting_q[1] <= 1'b0;
      missed_q[0]  <= 4'd0;
      missed_q[1]  <= 4'd0;
    end else if (accept_i) begin
      front_dist_q <= front_dist_d;
      side_dist_q  <= side_dist_d;
      waiting_q    <= waiting_d;
      missed_q     <= missed_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/urs_queue.sv =====
// Short queue of event words between the sensor front end and the steering
// back end. Uses urs_pkg for the word type and depth.
`timescale 1ns / 1ps
`default_nettype none

module urs_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire urs_pkg::evt_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output urs_pkg::evt_t      pop_data_o
);

  localparam int unsigned CNT_W = $clog2(urs_pkg::QUEUE_DEPTH + 1);

  urs_pkg::evt_t                 slot_q [urs_pkg::QUEUE_DEPTH];
  logic [urs_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]              count_q;

  assign full_o     = (count_q == CNT_W'(urs_pkg::QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == urs_pkg::QPTR_W'(urs_pkg::QUEUE_DEPTH - 1)) ? '0 :
                    wr_ptr_q + urs_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == urs_pkg::QPTR_W'(urs_pkg::QUEUE_DEPTH - 1)) ? '0 :
                    rd_ptr_q + urs_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/urs_back.sv =====
// Steering back end: runs the mode rule on each event word that asks for it,
// holds the last drives and registers the result word. Uses urs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urs_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          evt_valid_i,
  input  wire urs_pkg::evt_t evt_i,
  output logic               pop_o,
  input  wire logic [9:0]    follow_distance_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [11:0]        left_drive_o,
  output logic [11:0]        right_drive_o,
  output logic [15:0]        front_distance_o,
  output logic [15:0]        side_distance_o,
  output logic               fire_pulse_o,
  output logic               drive_updated_o
);

  logic        backing_q, backing_d;
  logic        turning_q, turning_d;
  logic        side_back_q, side_back_d;
  logic [11:0] left_hold_q, right_hold_q;
  logic [11:0] left_new, right_new;
  logic        out_valid_q;
  logic [11:0] left_q, right_q;
  logic [15:0] front_q, side_q;
  logic        fire_q, upd_q;

  urs_pkg::steer_t f, s, d, m, turn, fwd, turn_c, fwd_c;

  assign f = urs_pkg::steer_t'({8'b0, evt_i.front_dist});
  assign s = urs_pkg::steer_t'({8'b0, evt_i.side_dist});
  assign d = urs_pkg::steer_t'({14'b0, follow_distance_i});
  assign m = urs_pkg::TURN_GAIN + 24'sd3 * (urs_pkg::TURN_ENTER - f);

  always_comb begin
    backing_d   = backing_q;
    turning_d   = turning_q;
    side_back_d = side_back_q;
    turn        = '0;
    fwd         = '0;
    priority if ((f < urs_pkg::BACK_ENTER) || backing_q) begin
      fwd       = f * 24'sd7 - urs_pkg::BACK_BASE;
      backing_d = !(f > urs_pkg::BACK_EXIT);
    end else if ((f < urs_pkg::TURN_ENTER) || turning_q) begin
      // Turn by m when the side wall is within TURN_SIDE, by -m when it is farther.
      turn      = (s > urs_pkg::TURN_SIDE) ? -m : m;
      fwd       = f - urs_pkg::FWD_OFFSET;
      turning_d = !(f > urs_pkg::TURN_EXIT);
    end else if ((s < urs_pkg::SIDE_ENTER) || side_back_q) begin
      turn        = urs_pkg::SIDE_TURN;
      fwd         = s >>> 1;
      side_back_d = !(s > d + urs_pkg::SIDE_MARGIN);
    end else if (s < d * 24'sd3) begin
      fwd  = urs_pkg::FOLLOW_BASE + 24'sd3 * (s - urs_pkg::FOLLOW_REF);
      turn = d - s;
    end else begin
      fwd = urs_pkg::CRUISE_FWD;
    end
  end

  always_comb begin
    turn_c = turn;
    fwd_c  = fwd;
    if (turn > urs_pkg::TERM_LIMIT) begin
      turn_c = urs_pkg::TERM_LIMIT;
    end else if (turn < -urs_pkg::TERM_LIMIT) begin
      turn_c = -urs_pkg::TERM_LIMIT;
    end
    if (fwd > urs_pkg::TERM_LIMIT) begin
      fwd_c = urs_pkg::TERM_LIMIT;
    end else if (fwd < -urs_pkg::TERM_LIMIT) begin
      fwd_c = -urs_pkg::TERM_LIMIT;
    end
  end

  assign left_new  = 12'(fwd_c + turn_c);
  assign right_new = 12'(fwd_c - turn_c);

  // Take a word whenever the output register is empty or being emptied.
  assign pop_o = evt_valid_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backing_q    <= 1'b0;
      turning_q    <= 1'b0;
      side_back_q  <= 1'b0;
      left_hold_q  <= '0;
      right_hold_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o && evt_i.run_steer) begin
        backing_q    <= backing_d;
        turning_q    <= turning_d;
        side_back_q  <= side_back_d;
        left_hold_q  <= left_new;
        right_hold_q <= right_new;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      left_q  <= evt_i.run_steer ? left_new : left_hold_q;
      right_q <= evt_i.run_steer ? right_new : right_hold_q;
      front_q <= evt_i.front_dist;
      side_q  <= evt_i.side_dist;
      fire_q  <= evt_i.fire;
      upd_q   <= evt_i.run_steer;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_drive_o     = left_q;
  assign right_drive_o    = right_q;
  assign front_distance_o = front_q;
  assign side_distance_o  = side_q;
  assign fire_pulse_o     = fire_q;
  assign drive_updated_o  = upd_q;

endmodule

`default_nettype wire
